/* hdl/axdr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_pkg
// Shared types, tag codes and the tag classification table for the A-XDR
// element stream decoder.
// ----------------------------------------------------------------------------
package axdr_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_TAG,
        PH_SCALAR,
        PH_LEN0,
        PH_LEN81,
        PH_LEN82HI,
        PH_LEN82LO,
        PH_CONTENT
    } t_phase;

    // result kind
    typedef enum logic [1:0] {
        KIND_SCALAR,
        KIND_HEADER,
        KIND_BYTE,
        KIND_ERROR
    } t_kind;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_TAG,
        ERR_LEN_FORM,
        ERR_LEN_LIMIT
    } t_err;

    // tag classes
    typedef enum logic [1:0] {
        CLS_NULL,
        CLS_SCALAR,
        CLS_STRING,
        CLS_BAD
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [3:0] nbytes;
    } t_tag_info;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  type_tag;
        logic [63:0] value;
        logic [15:0] content_length;
        t_err        error_code;
        logic        last;
    } t_result;

    // tag codes
    localparam logic [7:0] TAG_NULL        = 8'd0;
    localparam logic [7:0] TAG_BOOLEAN     = 8'd3;
    localparam logic [7:0] TAG_BIT_STRING  = 8'd4;
    localparam logic [7:0] TAG_DLONG       = 8'd5;
    localparam logic [7:0] TAG_DLONG_U     = 8'd6;
    localparam logic [7:0] TAG_OCTET_STR   = 8'd9;
    localparam logic [7:0] TAG_VISIBLE_STR = 8'd10;
    localparam logic [7:0] TAG_UTF8_STR    = 8'd12;
    localparam logic [7:0] TAG_BCD         = 8'd13;
    localparam logic [7:0] TAG_INTEGER     = 8'd15;
    localparam logic [7:0] TAG_LONG        = 8'd16;
    localparam logic [7:0] TAG_UNSIGNED    = 8'd17;
    localparam logic [7:0] TAG_LONG_U      = 8'd18;
    localparam logic [7:0] TAG_LONG64      = 8'd20;
    localparam logic [7:0] TAG_LONG64_U    = 8'd21;
    localparam logic [7:0] TAG_ENUM        = 8'd22;
    localparam logic [7:0] TAG_FLOAT32     = 8'd23;
    localparam logic [7:0] TAG_FLOAT64     = 8'd24;

    // length prefix forms
    localparam logic [7:0] LEN_LONG1 = 8'h81;
    localparam logic [7:0] LEN_LONG2 = 8'h82;

    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    localparam int TDATA_W = 96;
    localparam int TUSER_W = 2;

    function automatic t_tag_info tag_info(input logic [7:0] tag);
        t_tag_info info;
        info.nbytes = 4'd0;
        case (tag)
            TAG_NULL:        info.cls = CLS_NULL;
            TAG_BOOLEAN, TAG_INTEGER, TAG_UNSIGNED, TAG_ENUM: begin
                info.cls    = CLS_SCALAR;
                info.nbytes = 4'd1;
            end
            TAG_LONG, TAG_LONG_U: begin
                info.cls    = CLS_SCALAR;
                info.nbytes = 4'd2;
            end
            TAG_DLONG, TAG_DLONG_U, TAG_FLOAT32: begin
                info.cls    = CLS_SCALAR;
                info.nbytes = 4'd4;
            end
            TAG_LONG64, TAG_LONG64_U, TAG_FLOAT64: begin
                info.cls    = CLS_SCALAR;
                info.nbytes = 4'd8;
            end
            TAG_BIT_STRING, TAG_OCTET_STR, TAG_VISIBLE_STR, TAG_UTF8_STR, TAG_BCD:
                info.cls = CLS_STRING;
            default:         info.cls = CLS_BAD;
        endcase
        return info;
    endfunction

endpackage

/* hdl/axdr_element_stream_decoder.sv */
`timescale 1ns / 1ps
// Results are registered before m_axis; one pushed while m_axis stalls waits in the skid stage.
// Throughput: one byte per cycle unless the skid stage is full.
// A result waiting on m_axis does not stop input; only a full skid stage does.
// Reset (synchronous, active low) returns the parser to tag phase, clears
// pending results and sets max_content_length to 65535.
// ----------------------------------------------------------------------------
// axdr_element_stream_decoder
// A-XDR data element decoder: tag, length prefix, scalar value and string
// content results from a byte stream.
// ----------------------------------------------------------------------------
module axdr_element_stream_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: max_content_length
    input  logic                           i_cfg_wr_en,
    input  logic [15:0]                    i_cfg_wr_data,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                     s_axis_tuser,   // [0] restart
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] type_tag, [71:8] value, [87:72] content_length,
    // [89:88] error_code, [95:90] zero
    output logic [axdr_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [axdr_pkg::TUSER_W-1:0]   m_axis_tuser,   // [1:0] kind
    output logic                           m_axis_tlast    // last
);
    import axdr_pkg::*;

    logic    accept;
    t_result res;

    assign accept = s_axis_tvalid && s_axis_tready;

    axdr_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (s_axis_tdata),
        .i_restart     (s_axis_tuser[0]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (res)
    );

    axdr_out_buf u_out_buf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (accept && res.valid),
        .i_res         (res),
        .o_ready       (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* hdl/axdr_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_parse
// Parser state registers and the per-byte decode: tag, length prefix,
// scalar gathering and string content, one byte per transaction.
// ----------------------------------------------------------------------------
module axdr_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_restart,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    output axdr_pkg::t_result o_res
);
    import axdr_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_len, n_len;
    logic [15:0] r_max_len;

    t_phase      phase_eff;
    t_tag_info   info;
    logic [15:0] len_sel;
    logic [16:0] bytes_wide;
    logic [15:0] bytes16;
    logic        over;
    logic        len_done;
    logic [15:0] rem_dec;
    logic [63:0] acc_shift;

    always_comb begin
        phase_eff = i_restart ? PH_TAG : r_phase;
        info      = tag_info(i_data_byte);
        rem_dec   = r_rem - 16'd1;
        acc_shift = {r_acc[55:0], i_data_byte};
        case (phase_eff)
            PH_LEN81:   len_sel = {8'h00, 1'b1, i_data_byte[6:0]};
            PH_LEN82LO: len_sel = {r_len[7:0], i_data_byte};
            default:    len_sel = {8'h00, i_data_byte};
        endcase
        // bit strings are sized by padded byte count
        if (r_tag == TAG_BIT_STRING) begin
            bytes_wide = ({1'b0, len_sel} + 17'd7) >> 3;
        end else begin
            bytes_wide = {1'b0, len_sel};
        end
        bytes16  = bytes_wide[15:0];
        over     = bytes_wide > {1'b0, r_max_len};
        len_done = (phase_eff == PH_LEN81) || (phase_eff == PH_LEN82LO) ||
                   ((phase_eff == PH_LEN0) && !i_data_byte[7]);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_tag   = r_tag;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_len   = r_len;
        if (len_done) begin
            n_len = len_sel;
            if (over) begin
                n_phase = PH_TAG;
                n_rem   = 16'd0;
            end else begin
                n_rem   = bytes16;
                n_phase = (bytes16 == 16'd0) ? PH_TAG : PH_CONTENT;
            end
        end else begin
            case (phase_eff)
                PH_SCALAR: begin
                    n_acc = acc_shift;
                    n_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_LEN0: begin
                    if (i_data_byte == LEN_LONG1) begin
                        n_phase = PH_LEN81;
                    end else if (i_data_byte == LEN_LONG2) begin
                        n_phase = PH_LEN82HI;
                    end else begin
                        n_phase = PH_TAG;
                        n_rem   = 16'd0;
                    end
                end
                PH_LEN82HI: begin
                    n_len   = {8'h00, i_data_byte};
                    n_phase = PH_LEN82LO;
                end
                PH_CONTENT: begin
                    n_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_TAG;
                    end
                end
                default: begin
                    n_tag = i_data_byte;
                    n_acc = 64'd0;
                    n_rem = 16'd0;
                    n_len = 16'd0;
                    case (info.cls)
                        CLS_STRING: n_phase = PH_LEN0;
                        CLS_SCALAR: begin
                            n_rem   = {12'd0, info.nbytes};
                            n_phase = PH_SCALAR;
                        end
                        default:    n_phase = PH_TAG;
                    endcase
                end
            endcase
        end
    end

    // result
    always_comb begin
        o_res                = '0;
        o_res.kind           = KIND_SCALAR;
        o_res.error_code     = ERR_NONE;
        o_res.type_tag       = (phase_eff == PH_TAG) ? i_data_byte : r_tag;
        if (len_done) begin
            o_res.valid          = 1'b1;
            o_res.content_length = len_sel;
            if (over) begin
                o_res.kind       = KIND_ERROR;
                o_res.error_code = ERR_LEN_LIMIT;
                o_res.last       = 1'b1;
            end else begin
                o_res.kind       = KIND_HEADER;
                o_res.last       = (bytes16 == 16'd0);
            end
        end else begin
            case (phase_eff)
                PH_SCALAR: begin
                    o_res.valid = (rem_dec == 16'd0);
                    o_res.value = acc_shift;
                    o_res.last  = 1'b1;
                end
                PH_LEN0: begin
                    // long forms other than 0x81 and 0x82 are malformed
                    if ((i_data_byte != LEN_LONG1) && (i_data_byte != LEN_LONG2)) begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_LEN_FORM;
                        o_res.last       = 1'b1;
                    end
                end
                PH_LEN82HI: o_res.valid = 1'b0;
                PH_CONTENT: begin
                    o_res.valid          = 1'b1;
                    o_res.kind           = KIND_BYTE;
                    o_res.value          = {56'd0, i_data_byte};
                    o_res.content_length = r_len;
                    o_res.last           = (rem_dec == 16'd0);
                end
                default: begin
                    case (info.cls)
                        CLS_NULL: begin
                            o_res.valid = 1'b1;
                            o_res.last  = 1'b1;
                        end
                        CLS_BAD: begin
                            o_res.valid      = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_TAG;
                            o_res.last       = 1'b1;
                        end
                        default: o_res.valid = 1'b0;
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_tag     <= 8'd0;
            r_acc     <= 64'd0;
            r_rem     <= 16'd0;
            r_len     <= 16'd0;
            r_max_len <= MAX_LEN_RESET;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_tag   <= n_tag;
                r_acc   <= n_acc;
                r_rem   <= n_rem;
                r_len   <= n_len;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    a_content_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONTENT) |-> (r_rem != 16'd0))
        else $error("content phase with no bytes remaining");

    a_scalar_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SCALAR) |-> ((r_rem != 16'd0) && (r_rem <= 16'd8)))
        else $error("scalar byte count out of range");

    a_len82_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (phase_eff == PH_LEN82HI)) |=> (r_phase == PH_LEN82LO))
        else $error("two-byte length did not advance to low byte");

endmodule

/* hdl/axdr_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axdr_out_buf
// Result register with a skid stage, so the parser keeps taking bytes while
// one result waits on the master side.
// ----------------------------------------------------------------------------
module axdr_out_buf (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  axdr_pkg::t_result              i_res,
    output logic                           o_ready,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [axdr_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic [axdr_pkg::TUSER_W-1:0]   m_axis_tuser,
    output logic                           m_axis_tlast
);
    import axdr_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && m_axis_tready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (!r_out_valid || pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.error_code, r_out.content_length,
                            r_out.value, r_out.type_tag};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output register is empty");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_ready && r_out_valid && !m_axis_tready) |=> r_skid_valid)
        else $error("result pushed during stall was not kept in skid stage");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && m_axis_tready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid stage did not move to output register");

endmodule
